// File: rtl/rcpm_pkg.sv
// ----------------------------------------------------------------------------
// rcpm_pkg
// Shared constants, codes and controller/datapath command types for the
// rational cubic polynomial mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpm_pkg;

  localparam int TBL_WORDS  = 88;
  localparam int NUM_TERMS  = 20;
  localparam int AXIS_WORDS = 2 * NUM_TERMS - 1;
  localparam int SRC_CTR    = 2 * AXIS_WORDS;
  localparam int SRC_INV    = SRC_CTR + 3;
  localparam int DST_CTR    = SRC_INV + 3;
  localparam int DST_SCL    = DST_CTR + 2;

  localparam int IN_TDATA_W  = 296;
  localparam int OUT_TDATA_W = 96;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_XFORM = 2'd1;
  localparam logic [1:0] REQ_RESID = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [63:0] ONE40 = 64'h0000_0100_0000_0000;
  localparam logic [63:0] MAX48 = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] LIM62 = 64'h4000_0000_0000_0000;

  localparam logic [4:0] MONO_A [NUM_TERMS] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd1, 5'd1, 5'd2, 5'd1, 5'd2, 5'd3,
    5'd7, 5'd8, 5'd9, 5'd4, 5'd7, 5'd7, 5'd4, 5'd8, 5'd5, 5'd6};
  localparam logic [4:0] MONO_B [NUM_TERMS] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd2, 5'd3, 5'd3, 5'd1, 5'd2, 5'd3,
    5'd1, 5'd2, 5'd3, 5'd3, 5'd2, 5'd3, 5'd2, 5'd3, 5'd3, 5'd3};

  typedef enum logic [1:0] {A_DIFF, A_TBL, A_TERM} a_sel_t;
  typedef enum logic [1:0] {B_TBL, B_TERM, B_NUM} b_sel_t;

  typedef struct packed {
    logic       capture;
    logic       tbl_we;
    logic [6:0] tbl_addr;
    logic [4:0] term_addr;
    logic       term_we;
    logic       term_one;
    a_sel_t     a_sel;
    logic       ld_a;
    logic [1:0] coord;
    b_sel_t     b_sel;
    logic       ld_b;
    logic       mul_step;
    logic       rnd;
    logic       shift40;
    logic       sat;
    logic       lim62;
    logic       acc_init;
    logic       num_add;
    logic       den_add;
    logic       div_init;
    logic       div_step;
    logic       div_rnd;
    logic       res_wr;
    logic       ax;
    logic       set_zero;
    logic       clr_zero;
    logic       out_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       idx_ok;
    logic       den_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/rcpm_dp.sv
// ----------------------------------------------------------------------------
// rcpm_dp
// Datapath: parameter and term memories, shared 64x16 multiplier, rounding and
// saturation, accumulators, restoring divider and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpm_dp (
  input  logic                                clk,
  input  rcpm_pkg::dp_cmd_t                   cmd,
  output rcpm_pkg::dp_stat_t                  stat,
  input  logic [1:0]                          in_tuser,  // req_type
  // word_index, word_value, src_x, src_y, src_z, obs_x, obs_y, zero pad
  input  logic [rcpm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  output logic [rcpm_pkg::OUT_TDATA_W-1:0]    out_tdata, // out_x, out_y
  output logic [1:0]                          out_tuser, // status
  output logic                                out_tlast
);
  import rcpm_pkg::*;

  logic [1:0]         req_r;
  logic [6:0]         idx_r;
  logic [47:0]        val_r;
  logic [47:0]        src_r [3];
  logic [47:0]        obs_x_r, obs_y_r;
  logic               last_r;

  logic [47:0]        tbl_mem [TBL_WORDS];
  logic [47:0]        tbl_rd_r;
  logic [47:0]        term_mem [NUM_TERMS];
  logic [47:0]        term_rd_r;

  logic [63:0]        a_mag_r, b_mag_r;
  logic               a_neg_r, neg_r, dneg_r;
  logic [127:0]       prod_r;
  logic [63:0]        mres_r;
  logic [63:0]        num_r, den_r, den_mag_r;
  logic [64:0]        rem_r;
  logic [63:0]        q_r;
  logic               qovf_r;
  logic [64:0]        res_r [2];
  logic               zero_r;
  logic [47:0]        out_x_r, out_y_r;
  logic [1:0]         out_st_r;
  logic               out_last_r;

  logic [48:0]        diff;
  logic [64:0]        a_val, b_val;
  logic [79:0]        pp;
  logic [127:0]       rsum;
  logic [63:0]        lim, satv;
  logic [64:0]        rem_sh, half, q65;
  logic               ge;
  logic [65:0]        rx, ry, tx, ty;

  function automatic logic [63:0] mag65(input logic [64:0] v);
    logic [64:0] n;
    n = v[64] ? (~v + 65'd1) : v;
    return n[63:0];
  endfunction

  function automatic logic [47:0] sat48(input logic [65:0] v);
    logic [47:0] r;
    if (v[65:47] == {19{v[65]}}) begin
      r = v[47:0];
    end else if (v[65]) begin
      r = 48'h8000_0000_0000;
    end else begin
      r = 48'h7FFF_FFFF_FFFF;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= in_tuser;
      idx_r    <= in_tdata[6:0];
      val_r    <= in_tdata[54:7];
      src_r[0] <= in_tdata[102:55];
      src_r[1] <= in_tdata[150:103];
      src_r[2] <= in_tdata[198:151];
      obs_x_r  <= in_tdata[246:199];
      obs_y_r  <= in_tdata[294:247];
      last_r   <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_we) begin
      tbl_mem[idx_r] <= val_r;
    end
    tbl_rd_r <= tbl_mem[cmd.tbl_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.term_we) begin
      term_mem[cmd.term_addr] <= cmd.term_one ? ONE40[47:0] : mres_r[47:0];
    end
    term_rd_r <= term_mem[cmd.term_addr];
  end

  always_comb begin
    diff = {src_r[cmd.coord][47], src_r[cmd.coord]} - {tbl_rd_r[47], tbl_rd_r};
    case (cmd.a_sel)
      A_DIFF:  a_val = {{16{diff[48]}}, diff};
      A_TBL:   a_val = {{17{tbl_rd_r[47]}}, tbl_rd_r};
      A_TERM:  a_val = {{17{term_rd_r[47]}}, term_rd_r};
      default: a_val = '0;
    endcase
    case (cmd.b_sel)
      B_TBL:   b_val = {{17{tbl_rd_r[47]}}, tbl_rd_r};
      B_TERM:  b_val = {{17{term_rd_r[47]}}, term_rd_r};
      B_NUM:   b_val = {num_r[63], num_r};
      default: b_val = '0;
    endcase
    pp     = a_mag_r * b_mag_r[63:48];
    rsum   = prod_r + (cmd.shift40 ? (128'd1 << 39) : (128'd1 << 23));
    lim    = (cmd.lim62 ? LIM62 : MAX48) + {63'd0, neg_r};
    satv   = (prod_r > {64'd0, lim}) ? lim : prod_r[63:0];
    rem_sh = {rem_r[63:0], prod_r[127]};
    ge     = rem_sh >= {1'b0, den_mag_r};
    half   = {1'b0, den_mag_r} - rem_r;
    q65    = {1'b0, q_r} + {64'd0, rem_r >= half};
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      a_mag_r <= mag65(a_val);
      a_neg_r <= a_val[64];
    end
    if (cmd.ld_b) begin
      b_mag_r <= mag65(b_val);
      neg_r   <= a_neg_r ^ b_val[64];
      prod_r  <= '0;
    end else if (cmd.mul_step) begin
      b_mag_r <= b_mag_r << 16;
      prod_r  <= (prod_r << 16) + {48'd0, pp};
    end else if (cmd.rnd) begin
      prod_r  <= cmd.shift40 ? (rsum >> 40) : (rsum >> 24);
    end else if (cmd.div_step) begin
      prod_r  <= prod_r << 1;
    end else if (cmd.div_rnd) begin
      prod_r  <= {62'd0, qovf_r, q65};
      neg_r   <= dneg_r;
    end
    if (cmd.sat) begin
      mres_r <= neg_r ? (~satv + 64'd1) : satv;
    end
    if (cmd.acc_init) begin
      num_r <= '0;
      den_r <= ONE40;
    end else if (cmd.num_add) begin
      num_r <= num_r + mres_r;
    end else if (cmd.den_add) begin
      den_r <= den_r + mres_r;
    end
    if (cmd.div_init) begin
      rem_r     <= '0;
      q_r       <= '0;
      qovf_r    <= 1'b0;
      dneg_r    <= neg_r ^ den_r[63];
      den_mag_r <= mag65({den_r[63], den_r});
    end else if (cmd.div_step) begin
      rem_r  <= ge ? (rem_sh - {1'b0, den_mag_r}) : rem_sh;
      q_r    <= {q_r[62:0], ge};
      qovf_r <= qovf_r | q_r[63];
    end
    if (cmd.res_wr) begin
      res_r[cmd.ax] <= {{17{tbl_rd_r[47]}}, tbl_rd_r} + {mres_r[63], mres_r};
    end
    if (cmd.clr_zero) begin
      zero_r <= 1'b0;
    end else if (cmd.set_zero) begin
      zero_r <= 1'b1;
    end
  end

  always_comb begin
    tx = {res_r[0][64], res_r[0]};
    ty = {res_r[1][64], res_r[1]};
    rx = {{18{obs_x_r[47]}}, obs_x_r} - tx;
    ry = {{18{obs_y_r[47]}}, obs_y_r} - ty;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_wr) begin
      out_last_r <= last_r;
      out_x_r    <= '0;
      out_y_r    <= '0;
      case (req_r)
        REQ_LOAD: begin
          out_st_r <= (idx_r < 7'(TBL_WORDS)) ? ST_OK : ST_BAD;
        end
        REQ_XFORM: begin
          out_st_r <= zero_r ? ST_ZERO : ST_OK;
          if (!zero_r) begin
            out_x_r <= sat48(tx);
            out_y_r <= sat48(ty);
          end
        end
        REQ_RESID: begin
          out_st_r <= zero_r ? ST_ZERO : ST_OK;
          if (!zero_r) begin
            out_x_r <= sat48(rx);
            out_y_r <= sat48(ry);
          end
        end
        default: begin
          out_st_r <= ST_BAD;
        end
      endcase
    end
  end

  assign stat.req      = req_r;
  assign stat.idx_ok   = idx_r < 7'(TBL_WORDS);
  assign stat.den_zero = den_r == 64'd0;

  assign out_tdata = {out_y_r, out_x_r};
  assign out_tuser = out_st_r;
  assign out_tlast = out_last_r;

endmodule

`default_nettype wire

// File: rtl/rcpm_ctrl.sv
// ----------------------------------------------------------------------------
// rcpm_ctrl
// Controller: sequences table loads, normalization, monomials, numerator and
// denominator sums, scaling and division, and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output rcpm_pkg::dp_cmd_t  cmd,
  input  rcpm_pkg::dp_stat_t stat
);
  import rcpm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_START, S_AXIS, S_RDA, S_LDA, S_LDB, S_MUL,
    S_RND, S_SAT, S_WB, S_ZCHK, S_DIVI, S_DIV, S_DRND, S_FIN
  } state_t;

  typedef enum logic [2:0] {PH_NORM, PH_MONO, PH_NUM, PH_DEN, PH_SCALE} phase_t;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       ax_r, ax_nxt;
  logic [4:0] t_r, t_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] base;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    ax_nxt        = ax_r;
    t_nxt         = t_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    base          = ax_r ? 7'(AXIS_WORDS) : 7'd0;
    in_tready     = state_r == S_IDLE;
    cmd.coord     = t_r[1:0];
    cmd.ax        = ax_r;
    cmd.shift40   = phase_r != PH_NORM;
    cmd.lim62     = phase_r inside {PH_NUM, PH_DEN, PH_SCALE};
    case (phase_r)
      PH_NORM: begin
        cmd.a_sel = A_DIFF;
        cmd.b_sel = B_TBL;
      end
      PH_MONO: begin
        cmd.a_sel = A_TERM;
        cmd.b_sel = B_TERM;
      end
      PH_SCALE: begin
        cmd.a_sel = A_TBL;
        cmd.b_sel = B_NUM;
      end
      default: begin
        cmd.a_sel = A_TBL;
        cmd.b_sel = B_TERM;
      end
    endcase

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.req == REQ_LOAD) begin
          cmd.tbl_we = stat.idx_ok;
          state_nxt  = S_FIN;
        end else if (stat.req inside {REQ_XFORM, REQ_RESID}) begin
          state_nxt = S_START;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_START: begin
        cmd.term_we   = 1'b1;
        cmd.term_one  = 1'b1;
        cmd.term_addr = 5'd0;
        cmd.clr_zero  = 1'b1;
        phase_nxt     = PH_NORM;
        t_nxt         = 5'd0;
        ax_nxt        = 1'b0;
        state_nxt     = S_RDA;
      end
      S_AXIS: begin
        cmd.acc_init = 1'b1;
        phase_nxt    = PH_NUM;
        t_nxt        = 5'd0;
        state_nxt    = S_RDA;
      end
      S_RDA: begin
        case (phase_r)
          PH_NORM:  cmd.tbl_addr = 7'(SRC_CTR) + 7'(t_r);
          PH_MONO:  cmd.term_addr = MONO_A[t_r];
          PH_NUM:   cmd.tbl_addr = base + 7'(t_r);
          PH_DEN:   cmd.tbl_addr = base + 7'(NUM_TERMS) + 7'(t_r) - 7'd1;
          PH_SCALE: cmd.tbl_addr = 7'(DST_SCL) + {6'd0, ax_r};
          default:  cmd.tbl_addr = 7'd0;
        endcase
        state_nxt = S_LDA;
      end
      S_LDA: begin
        cmd.ld_a = 1'b1;
        case (phase_r)
          PH_NORM: cmd.tbl_addr = 7'(SRC_INV) + 7'(t_r);
          PH_MONO: cmd.term_addr = MONO_B[t_r];
          default: cmd.term_addr = t_r;
        endcase
        state_nxt = S_LDB;
      end
      S_LDB: begin
        cmd.ld_b  = 1'b1;
        cnt_nxt   = 7'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 7'd1;
        if (cnt_r == 7'd3) begin
          state_nxt = (phase_r == PH_SCALE) ? S_DIVI : S_RND;
        end
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.sat      = 1'b1;
        cmd.tbl_addr = 7'(DST_CTR) + {6'd0, ax_r};
        state_nxt    = S_WB;
      end
      S_WB: begin
        state_nxt = S_RDA;
        t_nxt     = t_r + 5'd1;
        case (phase_r)
          PH_NORM: begin
            cmd.term_we   = 1'b1;
            cmd.term_addr = t_r + 5'd1;
            if (t_r == 5'd2) begin
              phase_nxt = PH_MONO;
              t_nxt     = 5'd4;
            end
          end
          PH_MONO: begin
            cmd.term_we   = 1'b1;
            cmd.term_addr = t_r;
            if (t_r == 5'(NUM_TERMS - 1)) begin
              ax_nxt    = 1'b0;
              state_nxt = S_AXIS;
            end
          end
          PH_NUM: begin
            cmd.num_add = 1'b1;
            if (t_r == 5'(NUM_TERMS - 1)) begin
              phase_nxt = PH_DEN;
              t_nxt     = 5'd1;
            end
          end
          PH_DEN: begin
            cmd.den_add = 1'b1;
            if (t_r == 5'(NUM_TERMS - 1)) begin
              state_nxt = S_ZCHK;
            end
          end
          default: begin
            cmd.res_wr = 1'b1;
            if (ax_r) begin
              state_nxt = S_FIN;
            end else begin
              ax_nxt    = 1'b1;
              state_nxt = S_AXIS;
            end
          end
        endcase
      end
      S_ZCHK: begin
        if (stat.den_zero) begin
          cmd.set_zero = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          phase_nxt = PH_SCALE;
          state_nxt = S_RDA;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = 7'd0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          state_nxt = S_DRND;
        end
      end
      S_DRND: begin
        cmd.div_rnd = 1'b1;
        state_nxt   = S_SAT;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_wr    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_NORM;
      ax_r        <= 1'b0;
      t_r         <= 5'd0;
      cnt_r       <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      ax_r        <= ax_nxt;
      t_r         <= t_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/rational_cubic_polynomial_mapper_top.sv
// A load or a bad request goes from decode straight to the finish state that registers its word.
// A transform or residual runs 97 products on one shared 64x16 multiplier (four digit steps)
// and, per axis, a scale and restoring division at one quotient bit per cycle over 128 bits.
// One item is in work at a time; a stalled output holds it in the finish state.
// Reset (synchronous, active low) clears control only; the table is undefined.
// ----------------------------------------------------------------------------
// rational_cubic_polynomial_mapper_top
// Third-order rational polynomial mapper from ground point to image point.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_cubic_polynomial_mapper_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // word_index, word_value, src_x, src_y, src_z, obs_x, obs_y, zero pad
  input  logic [rcpm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [1:0]                          in_tuser,  // req_type
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rcpm_pkg::OUT_TDATA_W-1:0]    out_tdata, // out_x, out_y
  output logic [1:0]                          out_tuser, // status
  output logic                                out_tlast
);
  import rcpm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rcpm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  rcpm_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .stat      (stat),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_wr |-> (!out_tvalid || out_tready))
    else $error("result register overwritten before it was taken");

  a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tbl_we |-> stat.idx_ok && stat.req == REQ_LOAD)
    else $error("table written outside a valid load");

  a_zero_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("nonzero values with an error status");
`endif

endmodule

`default_nettype wire
